// ===== rtl/crpn_pkg.sv =====
`timescale 1ns / 1ps
package crpn_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // token codes
    localparam logic [3:0] ACT_PUSH_CONST = 4'd0;
    localparam logic [3:0] ACT_PUSH_Z     = 4'd1;
    localparam logic [3:0] ACT_DUP        = 4'd2;
    localparam logic [3:0] ACT_DROP       = 4'd3;
    localparam logic [3:0] ACT_CONJ       = 4'd4;
    localparam logic [3:0] ACT_NEG        = 4'd5;
    localparam logic [3:0] ACT_ADD        = 4'd6;
    localparam logic [3:0] ACT_SUB        = 4'd7;
    localparam logic [3:0] ACT_MUL        = 4'd8;
    localparam logic [3:0] ACT_DIV        = 4'd9;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_DIVZ  = 2'd3;

    // configuration register indexes
    localparam logic CFG_Z_RE = 1'b0;
    localparam logic CFG_Z_IM = 1'b1;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOP,
        ST_RD_NEXT,
        ST_LOAD,
        ST_DECODE,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_DIV_INIT,
        ST_DIV_ITER,
        ST_DIV_FIN,
        ST_WB
    } crpn_state_t;

    // signed result from sign and magnitude, clamped to 32 bits
    function automatic logic [31:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [64:0] negv;
        negv = 65'd0 - mag;
        if (neg)
        begin
            if (mag >= 65'h0_8000_0000)
                return S32_MIN;
            return negv[31:0];
        end
        if (mag > 65'h0_7FFF_FFFF)
            return S32_MAX;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] sat_add(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic sub);
        logic signed [32:0] s;
        s = sub ? (33'(x) - 33'(y)) : (33'(x) + 33'(y));
        if (s > 33'sh0_7FFF_FFFF)
            return S32_MAX;
        if (s < -33'sh0_8000_0000)
            return S32_MIN;
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat_neg(input logic [31:0] x);
        logic [31:0] n;
        n = 32'd0 - x;
        return (x == S32_MIN) ? S32_MAX : n;
    endfunction

    // drop frac fractional bits, round half away from zero, clamp
    function automatic logic [31:0] round_sat(input logic signed [65:0] acc, input int frac);
        logic        neg;
        logic [65:0] mag;
        logic [65:0] r;
        neg = acc[65];
        mag = neg ? (66'd0 - acc) : acc;
        r   = (mag + (66'd1 << (frac - 1))) >> frac;
        return sat_mag(neg, r[64:0]);
    endfunction

endpackage

// ===== rtl/complex_rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Complex RPN stack evaluator.
// Feed one postfix token per s_axis beat: push constant, push z, dup, drop,
// conjugate, negate, add, subtract, multiply, divide. Values are signed
// Q16.16 complex numbers held on a small stack memory. Every token returns
// one m_axis beat with the new top of stack, the depth and a status code
// (ok, underflow, overflow, divide by zero); a failed token leaves the stack
// as it was. A token with tlast set marks the end of the expression: its
// result carries tlast and the stack empties afterwards.
// z is loaded through the cfg channel (index 0 real, 1 imaginary), always
// ready; the user must write it only while no token is in flight, as the
// block itself does not enforce this. Stack moves and add/sub go straight from
// decode to write-back; multiply runs four products through one 32x32
// multiplier, each through a multiply and an accumulate state, then rounds;
// divide runs six products, then one restoring divider producing one
// quotient bit per cycle for each part. One token is worked on at a time:
// s_axis_tready is high only when idle. A finished result waits in the
// output register; if the receiver stalls, the next token is taken but held
// at write-back. Reset empties the stack, clears z and drops any pending result.
module complex_rpn_stack_evaluator
    import crpn_pkg::*;
#(
    parameter int StackDepth = STACK_DEPTH_DEF,
    parameter int FracBits   = FRAC_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action[3:0], const_re[35:4], const_im[67:36], zero
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // top_re[31:0], top_im[63:32], depth[68:64],
                                       // status[70:69], zero
    output logic        m_axis_tlast,  // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(StackDepth);
    localparam int CW = $clog2(StackDepth + 1);
    localparam int QW = 32 + FracBits + 1;

    crpn_state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [31:0]   z_re_reg, z_im_reg;

    // latched token
    logic [3:0]    act_reg;
    logic [31:0]   cre_reg, cim_reg;
    logic          last_reg;

    // operands: (a,b) second entry, (c,d) top entry
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;

    // write-back plan
    logic [31:0]   res_re_reg, res_im_reg;
    logic [1:0]    status_reg;
    logic          wr_en_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [CW-1:0] cnt_new_reg;

    // shared multiplier and accumulators
    logic [2:0]         step_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_re_reg, acc_im_reg, acc_den_reg;

    // shared divider
    logic              part_reg;
    logic              dneg_reg, dovf_reg;
    logic [64:0]       rem_reg;
    logic [QW-1:0]     q_reg, sh_reg;
    logic [6:0]        dcnt_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] out_re_reg, out_im_reg;
    logic [4:0]  out_depth_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    // stack memory
    logic [63:0]   stack_mem [StackDepth];
    logic [63:0]   rdata_reg;
    logic [AW-1:0] raddr;

    logic [CW-1:0] cnt_m1, cnt_m2;
    logic          is_div, div_zero, go_arith, wb_fire, last_step;
    logic signed [31:0] mul_x, mul_y;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign is_div   = (act_reg == ACT_DIV);
    assign div_zero = (c_reg == 32'sd0) && (d_reg == 32'sd0);
    assign go_arith = (count_reg >= CW'(2)) &&
                      ((act_reg == ACT_MUL) || (is_div && !div_zero));
    assign wb_fire  = (state_reg == ST_WB) && (!out_valid_reg || m_axis_tready);
    assign last_step = is_div ? (step_reg == 3'd5) : (step_reg == 3'd3);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_axis_tvalid) state_next = ST_RD_TOP;
            ST_RD_TOP:   state_next = ST_RD_NEXT;
            ST_RD_NEXT:  state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_DECODE;
            ST_DECODE:   state_next = go_arith ? ST_MUL : ST_WB;
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:
            begin
                if (!last_step)
                    state_next = ST_MUL;
                else
                    state_next = is_div ? ST_DIV_INIT : ST_RND;
            end
            ST_RND:      state_next = ST_WB;
            ST_DIV_INIT: state_next = ST_DIV_ITER;
            ST_DIV_ITER: if (dcnt_reg == 7'd1) state_next = ST_DIV_FIN;
            ST_DIV_FIN:  state_next = part_reg ? ST_WB : ST_DIV_INIT;
            ST_WB:       if (wb_fire) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and control
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        raddr = cnt_m1[AW-1:0];
        if (state_reg == ST_RD_NEXT)
            raddr = cnt_m2[AW-1:0];
        mul_x = a_reg;
        mul_y = c_reg;
        case (step_reg)
            3'd1:    begin mul_x = b_reg; mul_y = d_reg; end
            3'd2:    begin mul_x = a_reg; mul_y = d_reg; end
            3'd3:    begin mul_x = b_reg; mul_y = c_reg; end
            3'd4:    begin mul_x = c_reg; mul_y = c_reg; end
            3'd5:    begin mul_x = d_reg; mul_y = d_reg; end
            default: begin mul_x = a_reg; mul_y = c_reg; end
        endcase
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_status_reg, out_depth_reg, out_im_reg, out_re_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            z_re_reg      <= '0;
            z_im_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_Z_RE)
                    z_re_reg <= cfg_data;
                else
                    z_im_reg <= cfg_data;
            end
            if (wb_fire)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= last_reg ? '0 : cnt_new_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (wb_fire && wr_en_reg)
            stack_mem[wr_addr_reg] <= {res_im_reg, res_re_reg};
        rdata_reg <= stack_mem[raddr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                act_reg  <= s_axis_tdata[3:0];
                cre_reg  <= s_axis_tdata[35:4];
                cim_reg  <= s_axis_tdata[67:36];
                last_reg <= s_axis_tlast;
            end
            ST_RD_NEXT:
            begin
                c_reg <= rdata_reg[31:0];
                d_reg <= rdata_reg[63:32];
            end
            ST_LOAD:
            begin
                a_reg <= rdata_reg[31:0];
                b_reg <= rdata_reg[63:32];
            end
            ST_DECODE:
            begin
                status_reg  <= STAT_OK;
                wr_en_reg   <= 1'b0;
                wr_addr_reg <= cnt_m2[AW-1:0];
                cnt_new_reg <= count_reg;
                res_re_reg  <= (count_reg != '0) ? c_reg : 32'd0;
                res_im_reg  <= (count_reg != '0) ? d_reg : 32'd0;
                step_reg    <= 3'd0;
                acc_re_reg  <= '0;
                acc_im_reg  <= '0;
                acc_den_reg <= '0;
                part_reg    <= 1'b0;
                unique case (act_reg)
                    ACT_PUSH_CONST, ACT_PUSH_Z, ACT_DUP:
                    begin
                        if (act_reg == ACT_DUP && count_reg == '0)
                            status_reg <= STAT_UNDER;
                        else if (count_reg >= CW'(StackDepth))
                            status_reg <= STAT_OVER;
                        else
                        begin
                            wr_en_reg   <= 1'b1;
                            wr_addr_reg <= count_reg[AW-1:0];
                            cnt_new_reg <= count_reg + CW'(1);
                            if (act_reg == ACT_PUSH_CONST)
                            begin
                                res_re_reg <= cre_reg;
                                res_im_reg <= cim_reg;
                            end
                            else if (act_reg == ACT_PUSH_Z)
                            begin
                                res_re_reg <= z_re_reg;
                                res_im_reg <= z_im_reg;
                            end
                        end
                    end
                    ACT_DROP, ACT_CONJ, ACT_NEG:
                    begin
                        if (count_reg == '0)
                            status_reg <= STAT_UNDER;
                        else if (act_reg == ACT_DROP)
                        begin
                            cnt_new_reg <= cnt_m1;
                            res_re_reg  <= (count_reg >= CW'(2)) ? a_reg : 32'd0;
                            res_im_reg  <= (count_reg >= CW'(2)) ? b_reg : 32'd0;
                        end
                        else
                        begin
                            wr_en_reg   <= 1'b1;
                            wr_addr_reg <= cnt_m1[AW-1:0];
                            res_im_reg  <= sat_neg(d_reg);
                            if (act_reg == ACT_NEG)
                                res_re_reg <= sat_neg(c_reg);
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                    begin
                        if (count_reg < CW'(2))
                            status_reg <= STAT_UNDER;
                        else if (is_div && div_zero)
                            status_reg <= STAT_DIVZ;
                        else
                        begin
                            wr_en_reg   <= 1'b1;
                            cnt_new_reg <= cnt_m1;
                            res_re_reg  <= sat_add(a_reg, c_reg, act_reg == ACT_SUB);
                            res_im_reg  <= sat_add(b_reg, d_reg, act_reg == ACT_SUB);
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL:
            begin
                prod_reg <= mul_x * mul_y;
            end
            ST_ACC:
            begin
                step_reg <= step_reg + 3'd1;
                case (step_reg)
                    3'd0:    acc_re_reg <= acc_re_reg + 66'(prod_reg);
                    3'd1:    acc_re_reg <= is_div ? acc_re_reg + 66'(prod_reg)
                                                  : acc_re_reg - 66'(prod_reg);
                    3'd2:    acc_im_reg <= is_div ? acc_im_reg - 66'(prod_reg)
                                                  : acc_im_reg + 66'(prod_reg);
                    3'd3:    acc_im_reg <= acc_im_reg + 66'(prod_reg);
                    default: acc_den_reg <= acc_den_reg + 66'(prod_reg);
                endcase
            end
            ST_RND:
            begin
                res_re_reg <= round_sat(acc_re_reg, FracBits);
                res_im_reg <= round_sat(acc_im_reg, FracBits);
            end
            ST_DIV_INIT:
            begin : div_init
                logic signed [65:0] src;
                logic [65:0]        mag;
                src = part_reg ? acc_im_reg : acc_re_reg;
                mag = src[65] ? (66'd0 - src) : src;
                dneg_reg <= src[65];
                dovf_reg <= {32'd0, mag[63:0]} >= {acc_den_reg[63:0], 32'd0};
                rem_reg  <= 65'(mag[63:32]);
                sh_reg   <= {mag[31:0], (FracBits + 1)'(0)};
                q_reg    <= '0;
                dcnt_reg <= 7'(QW);
            end
            ST_DIV_ITER:
            begin : div_iter
                logic [64:0] trial;
                trial = {rem_reg[63:0], sh_reg[QW-1]};
                if (trial >= {1'b0, acc_den_reg[63:0]})
                begin
                    rem_reg <= trial - {1'b0, acc_den_reg[63:0]};
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
                sh_reg   <= {sh_reg[QW-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - 7'd1;
            end
            ST_DIV_FIN:
            begin : div_fin
                logic [QW:0] m;
                logic [31:0] r;
                m = ({1'b0, q_reg} + (QW+1)'(1)) >> 1;
                r = dovf_reg ? (dneg_reg ? S32_MIN : S32_MAX)
                             : sat_mag(dneg_reg, 65'(m));
                if (part_reg)
                    res_im_reg <= r;
                else
                    res_re_reg <= r;
                part_reg <= 1'b1;
            end
            ST_WB:
            begin
                if (wb_fire)
                begin
                    out_re_reg     <= res_re_reg;
                    out_im_reg     <= res_im_reg;
                    out_depth_reg  <= 5'(cnt_new_reg);
                    out_status_reg <= status_reg;
                    out_last_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(StackDepth))
        else $error("stack count beyond depth");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_fire && last_reg) |=> (count_reg == '0))
        else $error("stack not cleared after last token");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_ITER) |-> (dcnt_reg != 7'd0))
        else $error("divider ran past its bit count");

    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_fire && !last_reg && status_reg != STAT_OK) |=> $stable(count_reg))
        else $error("failed token changed the depth");
`endif

endmodule
